// File: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; expects clk and arst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define KWRM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define KWRM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/kwrm_pkg.sv
// shared constants, types and key extraction for the k-way record merger
// no dependencies
package kwrm_pkg;

	localparam int Ways        = 8;
	localparam int WayW        = 3;
	localparam int RecordBytes = 8;
	localparam int RecW        = 64;
	localparam int ActW        = 4;
	localparam int OffW        = 3;
	localparam int KeyBytesW   = 4;
	localparam int CfgIdxW     = 2;
	localparam int CfgDataW    = 4;
	localparam int CntW        = 4;

	localparam logic [CfgIdxW-1:0] CfgActiveWays = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgKeyOffset  = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgKeyBytes   = 2'd2;

	localparam logic [ActW-1:0]      ActiveReset   = 4'd8;
	localparam logic [OffW-1:0]      OffsetReset   = 3'd0;
	localparam logic [KeyBytesW-1:0] KeyBytesReset = 4'd8;
	localparam logic [KeyBytesW-1:0] KeyBytesMax   = 4'd8;
	localparam logic [CntW-1:0]      MaxEmits      = CntW'(Ways);

	localparam logic [RecW-1:0] RecMask = (RecordBytes >= 8) ? {RecW{1'b1}} :
		((RecW'(1) << (8 * RecordBytes)) - RecW'(1));

	typedef struct packed {
		logic             in_ready;
		logic             accept;
		logic             store;
		logic             scan_clear;
		logic             rd_en;
		logic [WayW-1:0]  rd_addr;
		logic             take_best;
		logic             push_pend;
		logic             push_rej;
		logic             burst_end;
	} cmd_t;

	typedef struct packed {
		logic             reject;
		logic             go_ready;
		logic             all_retired;
		logic [WayW-1:0]  last_way;
		logic             out_free;
	} stat_t;

	// little-endian key of kb bytes at byte offset off, unsigned
	function automatic logic [RecW-1:0] key_of(input logic [RecW-1:0] rec,
			input logic [OffW-1:0] off, input logic [KeyBytesW-1:0] kb);
		logic [KeyBytesW-1:0] nb;
		logic [RecW-1:0]      sh;
		logic [RecW-1:0]      mask;
		nb = (kb > KeyBytesMax) ? KeyBytesMax : kb;
		sh = (rec & RecMask) >> {off, 3'b000};
		if (nb == KeyBytesMax) begin
			mask = {RecW{1'b1}};
		end else begin
			mask = (RecW'(1) << {nb, 3'b000}) - RecW'(1);
		end
		return sh & mask;
	endfunction

endpackage

// File: hw/rtl/kwrm_datapath.sv
// datapath: config registers, head memory, way flags, min-key scan, output register
// depends on kwrm_pkg
module kwrm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kwrm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [kwrm_pkg::CfgDataW-1:0] cfg_data,
	input  logic [kwrm_pkg::RecW-1:0]     in_record,
	input  logic [kwrm_pkg::WayW-1:0]     in_way,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [kwrm_pkg::RecW-1:0]     out_record,   // merged_record
	output logic [kwrm_pkg::WayW+1:0]     out_user,     // source_way, burst_end, rejected
	output logic                          out_last,     // merge_done
	input  kwrm_pkg::cmd_t                cmd,
	output kwrm_pkg::stat_t               stat
);

	logic [kwrm_pkg::ActW-1:0]      active_q;
	logic [kwrm_pkg::OffW-1:0]      koff_q;
	logic [kwrm_pkg::KeyBytesW-1:0] kbytes_q;

	logic [kwrm_pkg::RecW-1:0] head_mem [kwrm_pkg::Ways];
	logic [kwrm_pkg::Ways-1:0] valid_q;
	logic [kwrm_pkg::Ways-1:0] final_q;
	logic [kwrm_pkg::Ways-1:0] retired_q;

	logic [kwrm_pkg::RecW-1:0] rd_data_s1;
	logic                      rd_en_s1;
	logic [kwrm_pkg::WayW-1:0] rd_idx_s1;

	logic                      any_q;
	logic [kwrm_pkg::WayW-1:0] best_q;
	logic [kwrm_pkg::RecW-1:0] best_key_q;
	logic [kwrm_pkg::RecW-1:0] best_rec_q;

	logic [kwrm_pkg::RecW-1:0] pend_rec_q;
	logic [kwrm_pkg::WayW-1:0] pend_way_q;
	logic [kwrm_pkg::WayW-1:0] in_way_q;

	logic                      out_valid_q;
	logic [kwrm_pkg::RecW-1:0] out_rec_q;
	logic [kwrm_pkg::WayW-1:0] out_way_q;
	logic                      out_done_q;
	logic                      out_bend_q;
	logic                      out_rej_q;

	logic [kwrm_pkg::ActW-1:0] n_eff;
	logic [kwrm_pkg::Ways-1:0] act;
	logic [kwrm_pkg::RecW-1:0] scan_key;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= kwrm_pkg::ActiveReset;
			koff_q   <= kwrm_pkg::OffsetReset;
			kbytes_q <= kwrm_pkg::KeyBytesReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				kwrm_pkg::CfgActiveWays: active_q <= cfg_data;
				kwrm_pkg::CfgKeyOffset:  koff_q   <= cfg_data[kwrm_pkg::OffW-1:0];
				kwrm_pkg::CfgKeyBytes:   kbytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective way count and active mask
	always_comb begin
		if (active_q == '0) begin
			n_eff = kwrm_pkg::ActW'(1);
		end else if (active_q > kwrm_pkg::ActW'(kwrm_pkg::Ways)) begin
			n_eff = kwrm_pkg::ActW'(kwrm_pkg::Ways);
		end else begin
			n_eff = active_q;
		end
		for (int i = 0; i < kwrm_pkg::Ways; i++) begin
			act[i] = kwrm_pkg::ActW'(i) < n_eff;
		end
	end

	always_comb begin
		stat.reject      = ({1'b0, in_way} >= n_eff) || valid_q[in_way] || retired_q[in_way];
		stat.all_retired = ~|(act & ~retired_q);
		stat.go_ready    = (&(retired_q | valid_q | ~act)) && !stat.all_retired;
		stat.last_way    = kwrm_pkg::WayW'(n_eff - kwrm_pkg::ActW'(1));
		stat.out_free    = !out_valid_q || out_ready;
	end

	// head memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			head_mem[in_way] <= in_record & kwrm_pkg::RecMask;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= head_mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			final_q   <= '0;
			retired_q <= '0;
		end else if (cmd.store) begin
			valid_q[in_way] <= 1'b1;
			final_q[in_way] <= in_last;
		end else if (cmd.take_best) begin
			valid_q[best_q] <= 1'b0;
			if (final_q[best_q]) begin
				retired_q[best_q] <= 1'b1;
				final_q[best_q]   <= 1'b0;
			end
		end
	end

	assign scan_key = kwrm_pkg::key_of(rd_data_s1, koff_q, kbytes_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1 <= 1'b0;
			any_q    <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.rd_en;
			if (cmd.scan_clear) begin
				any_q <= 1'b0;
			end else if (rd_en_s1 && !retired_q[rd_idx_s1] &&
					(!any_q || scan_key < best_key_q)) begin
				any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cmd.rd_addr;
		if (rd_en_s1 && !cmd.scan_clear && !retired_q[rd_idx_s1] &&
				(!any_q || scan_key < best_key_q)) begin
			best_q     <= rd_idx_s1;
			best_key_q <= scan_key;
			best_rec_q <= rd_data_s1;
		end
		if (cmd.take_best) begin
			pend_rec_q <= best_rec_q;
			pend_way_q <= best_q;
		end
		if (cmd.accept) begin
			in_way_q <= in_way;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_pend || cmd.push_rej) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_pend) begin
			out_rec_q  <= pend_rec_q;
			out_way_q  <= pend_way_q;
			out_done_q <= stat.all_retired;
			out_bend_q <= cmd.burst_end;
			out_rej_q  <= 1'b0;
		end else if (cmd.push_rej) begin
			out_rec_q  <= '0;
			out_way_q  <= in_way_q;
			out_done_q <= 1'b0;
			out_bend_q <= 1'b1;
			out_rej_q  <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_record = out_rec_q;
	assign out_user   = {out_rej_q, out_bend_q, out_way_q};
	assign out_last   = out_done_q;

endmodule

// File: hw/rtl/kwrm_ctrl.sv
// controller: sequences accept, head scan, emit and result hand-off
// depends on kwrm_pkg
module kwrm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  kwrm_pkg::stat_t stat,
	output kwrm_pkg::cmd_t  cmd
);

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StRej   = 3'd1;
	localparam logic [2:0] StCheck = 3'd2;
	localparam logic [2:0] StScan  = 3'd3;
	localparam logic [2:0] StDrain = 3'd4;
	localparam logic [2:0] StEmit  = 3'd5;

	logic [2:0]                state_q;
	logic [2:0]                state_d;
	logic [kwrm_pkg::WayW-1:0] scan_q;
	logic [kwrm_pkg::CntW-1:0] count_q;
	logic                      pend_q;
	logic                      go;

	assign go = stat.go_ready && (count_q != kwrm_pkg::MaxEmits);

	always_comb begin
		cmd            = '0;
		cmd.rd_addr    = scan_q;
		state_d        = state_q;
		case (state_q)
			StIdle: begin
				cmd.in_ready = 1'b1;
				cmd.accept   = in_valid;
				if (in_valid) begin
					cmd.store = !stat.reject;
					state_d   = stat.reject ? StRej : StCheck;
				end
			end
			StRej: begin
				if (stat.out_free) begin
					cmd.push_rej = 1'b1;
					state_d      = StIdle;
				end
			end
			StCheck: begin
				if (!pend_q || stat.out_free) begin
					cmd.push_pend  = pend_q;
					cmd.burst_end  = !go;
					cmd.scan_clear = go;
					state_d        = go ? StScan : StIdle;
				end
			end
			StScan: begin
				cmd.rd_en = 1'b1;
				if (scan_q == stat.last_way) begin
					state_d = StDrain;
				end
			end
			StDrain: begin
				state_d = StEmit;
			end
			StEmit: begin
				cmd.take_best = 1'b1;
				state_d       = StCheck;
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			scan_q  <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.scan_clear) begin
				scan_q <= '0;
			end else if (cmd.rd_en) begin
				scan_q <= scan_q + kwrm_pkg::WayW'(1);
			end
			if (cmd.accept) begin
				count_q <= '0;
			end else if (cmd.take_best) begin
				count_q <= count_q + kwrm_pkg::CntW'(1);
			end
			if (cmd.take_best) begin
				pend_q <= 1'b1;
			end else if (cmd.push_pend) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/k_way_record_merger.sv
// rejected item: held in a reject state until the output register is free, then its result is loaded there
// accepted item: each emitted record is chosen by a scan over the n effective active ways
// of the head memory, one way per cycle through its registered read port
// an item causes up to eight results; the next item is taken once its burst is handed off
// reset (arst_n low, asynchronous): flags, control and config to defaults; head memory kept
// top level of the k-way record merger; depends on kwrm_pkg, kwrm_ctrl, kwrm_datapath, assert_macros.svh
`include "assert_macros.svh"
module k_way_record_merger (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [kwrm_pkg::RecW-1:0]     s_axis_tdata,   // record
	input  logic [kwrm_pkg::WayW-1:0]     s_axis_tuser,   // way
	input  logic                          s_axis_tlast,   // last_of_way
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [kwrm_pkg::RecW-1:0]     m_axis_tdata,   // merged_record
	output logic [kwrm_pkg::WayW+1:0]     m_axis_tuser,   // source_way, burst_end, rejected
	output logic                          m_axis_tlast,   // merge_done
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kwrm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [kwrm_pkg::CfgDataW-1:0] cfg_data
);

	kwrm_pkg::cmd_t  cmd;
	kwrm_pkg::stat_t stat;

	kwrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	kwrm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_record  (s_axis_tdata),
		.in_way     (s_axis_tuser),
		.in_last    (s_axis_tlast),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_record (m_axis_tdata),
		.out_user   (m_axis_tuser),
		.out_last   (m_axis_tlast),
		.cmd        (cmd),
		.stat       (stat)
	);

	assign s_axis_tready = cmd.in_ready;

	`KWRM_ASSERT_IMPL(a_store_not_rejected, cmd.store, !stat.reject, "store of a rejected item")
	`KWRM_ASSERT_IMPL(a_done_ends_burst, m_axis_tvalid && m_axis_tlast, m_axis_tuser[3] && !m_axis_tuser[4], "merge done without burst end")
	`KWRM_ASSERT_IMPL(a_push_needs_room, cmd.push_pend || cmd.push_rej, stat.out_free, "result pushed into a full output register")
	`KWRM_ASSERT_NEXT(a_emit_then_check, cmd.take_best, !s_axis_tready, "input taken right after an emit")

endmodule
